/* hdl/lmrs_pkg.sv */
// Shared types and constants of the LED matrix row scanner.
package lmrs_pkg;

  // Shift steps per row, one bit into each 32-bit chain per step.
  localparam int unsigned SHIFT_STEPS = 32;
  // Width of the step counter: enough for the blank step index.
  localparam int unsigned STEP_CNT_W  = 6;
  // Step indexes of the light and blank steps.
  localparam logic [STEP_CNT_W-1:0] LIGHT_STEP = STEP_CNT_W'(32);
  localparam logic [STEP_CNT_W-1:0] BLANK_STEP = STEP_CNT_W'(33);

  // Kind of one result step.
  typedef enum logic [1:0] {
    STEP_SHIFT = 2'd0,
    STEP_LIGHT = 2'd1,
    STEP_BLANK = 2'd2
  } step_kind_t;

  // One classified row, as it waits between the front and the back end.
  // Bit i of each sequence is the chain bit for shift step i.
  typedef struct packed {
    logic [SHIFT_STEPS-1:0] left_seq;
    logic [SHIFT_STEPS-1:0] right_seq;
    logic                   upper_half;
    logic [7:0]             row_select;
  } lmrs_entry_t;

  localparam int unsigned ENTRY_W = $bits(lmrs_entry_t);

endpackage

/* hdl/lmrs_front.sv */
// Front end: classifies an incoming row into panel half, select code and chain bit order.
module lmrs_front (
  input  logic [5:0]           row_number,
  input  logic [63:0]          row_bits,
  input  logic                 mirror,
  output lmrs_pkg::lmrs_entry_t entry
);

  logic       lower;
  logic       descending;
  logic [5:0] phys_row;
  logic [5:0] phys_minus;
  logic [63:0] scan_word;
  logic [31:0] hi_word;
  logic [31:0] lo_word;
  logic [31:0] hi_seq;
  logic [31:0] lo_seq;
  logic [7:0]  sel_code;

  // Rows above 25 sit on the lower panels; the upper panels count rows upside down.
  assign lower      = row_number > 6'd25;
  assign descending = lower ^ mirror;
  assign phys_row   = lower ? (row_number - 6'd25) : (6'd26 - row_number);
  assign phys_minus = phys_row - 6'd15;

  // Ascending scans use the row moved up by seven columns.
  assign scan_word = descending ? row_bits : {row_bits[56:0], 7'b0};
  assign hi_word   = scan_word[63:32];
  assign lo_word   = scan_word[31:0];

  // Put the bits in step order: a descending scan reads each half from the top.
  always_comb begin
    for (int i = 0; i < 32; i++) begin
      hi_seq[i] = descending ? hi_word[31-i] : hi_word[i];
      lo_seq[i] = descending ? lo_word[31-i] : lo_word[i];
    end
  end

  // Multiplexer select: low nibble for rows 1 to 15, high nibble for rows 16 to 25.
  always_comb begin
    if (phys_row >= 6'd1 && phys_row <= 6'd15) begin
      sel_code = {2'b00, phys_row};
    end else if (phys_row >= 6'd16 && phys_row <= 6'd25) begin
      sel_code = {phys_minus[3:0], 4'b0000};
    end else begin
      sel_code = 8'd0;
    end
  end

  // The high chain is the right one unless the row is mirrored.
  assign entry.left_seq   = mirror ? hi_seq : lo_seq;
  assign entry.right_seq  = mirror ? lo_seq : hi_seq;
  assign entry.upper_half = ~lower;
  assign entry.row_select = sel_code;

endmodule

/* hdl/lmrs_queue.sv */
// Short first-in first-out queue of classified rows between front and back end.
module lmrs_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r,  count_nxt;

  assign full      = count_r == CW'(DEPTH);
  assign not_empty = count_r != '0;
  assign pop_data  = slot_r[rd_ptr_r];

  // Pointer and fill count update, wrapping at the depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage slots need no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue fill count beyond depth");
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("queue popped while empty");
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + CW'(1))
    else $error("queue count did not grow on push");
`endif

endmodule

/* hdl/lmrs_back.sv */
// Back end: steps through the 34 drive steps of each queued row into an output register.
module lmrs_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_not_empty,
  input  lmrs_pkg::lmrs_entry_t q_entry,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lmrs_pkg::step_kind_t  out_kind,
  output logic                  out_half,
  output logic                  out_left,
  output logic                  out_right,
  output logic [7:0]            out_sel,
  output logic                  out_last
);

  logic                                active_r;
  logic [lmrs_pkg::STEP_CNT_W-1:0]     step_r;
  logic [lmrs_pkg::SHIFT_STEPS-1:0]    left_sr_r;
  logic [lmrs_pkg::SHIFT_STEPS-1:0]    right_sr_r;
  logic                                half_r;
  logic [7:0]                          sel_r;
  logic                                advance;
  logic                                at_blank;

  logic                                out_valid_r;
  lmrs_pkg::step_kind_t                out_kind_r;
  logic                                out_half_r;
  logic                                out_left_r;
  logic                                out_right_r;
  logic [7:0]                          out_sel_r;
  logic                                out_last_r;

  // A step moves into the output register whenever that register is free or being drained.
  assign advance  = active_r && (!out_valid_r || out_ready);
  assign at_blank = step_r == lmrs_pkg::BLANK_STEP;
  // The next row is loaded while the blank step of the current one goes out.
  assign q_pop    = q_not_empty && (!active_r || (advance && at_blank));

  // Sequencer control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        active_r <= 1'b1;
        step_r   <= '0;
      end else if (advance) begin
        if (at_blank) begin
          active_r <= 1'b0;
        end
        step_r <= step_r + lmrs_pkg::STEP_CNT_W'(1);
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Row data and chain shift registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      left_sr_r  <= q_entry.left_seq;
      right_sr_r <= q_entry.right_seq;
      half_r     <= q_entry.upper_half;
      sel_r      <= q_entry.row_select;
    end else if (advance && step_r < lmrs_pkg::LIGHT_STEP) begin
      left_sr_r  <= {1'b0, left_sr_r[lmrs_pkg::SHIFT_STEPS-1:1]};
      right_sr_r <= {1'b0, right_sr_r[lmrs_pkg::SHIFT_STEPS-1:1]};
    end
  end

  // Output register payload for the step being issued.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_half_r <= half_r;
      if (step_r < lmrs_pkg::LIGHT_STEP) begin
        out_kind_r  <= lmrs_pkg::STEP_SHIFT;
        out_left_r  <= left_sr_r[0];
        out_right_r <= right_sr_r[0];
        out_sel_r   <= 8'd0;
        out_last_r  <= 1'b0;
      end else if (step_r == lmrs_pkg::LIGHT_STEP) begin
        out_kind_r  <= lmrs_pkg::STEP_LIGHT;
        out_left_r  <= 1'b0;
        out_right_r <= 1'b0;
        out_sel_r   <= sel_r;
        out_last_r  <= 1'b0;
      end else begin
        out_kind_r  <= lmrs_pkg::STEP_BLANK;
        out_left_r  <= 1'b0;
        out_right_r <= 1'b0;
        out_sel_r   <= 8'd0;
        out_last_r  <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_half  = out_half_r;
  assign out_left  = out_left_r;
  assign out_right = out_right_r;
  assign out_sel   = out_sel_r;
  assign out_last  = out_last_r;

`ifndef SYNTHESIS
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> step_r <= lmrs_pkg::BLANK_STEP)
    else $error("step counter beyond blank step");
  a_last_is_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> out_kind_r == lmrs_pkg::STEP_BLANK)
    else $error("last flag on a step that is not the blank step");
  a_sel_only_light: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != lmrs_pkg::STEP_LIGHT) |-> out_sel_r == 8'd0)
    else $error("row select driven outside the light step");
  a_pop_idle_or_end: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!active_r || at_blank))
    else $error("new row loaded in the middle of a sequence");
`endif

endmodule

/* hdl/led_matrix_row_scanner_top.sv */
// Top level of the LED matrix row scanner: stream ports, front end, row queue and back end.
//
// Each accepted transaction is one display row; the block answers with 34 result
// transactions: 32 shift steps carrying one bit for each of the left and right 32-bit
// chains, a light step carrying the row's multiplexer select code, and a blank step
// flagged with out_tlast. Rows 26 to 50 drive the lower panel pair, rows 1 to 25 the
// upper pair. The back end's step sequencer issues one step per cycle while the output
// register is not held by a stalled out_tready; the front end classifies a row in the
// cycle it arrives and a queue of QUEUE_DEPTH rows lets input be taken while the previous
// row is still being sent, so rows stream with no gap between sequences. The result
// is held in an output register until taken. There is no configuration and no start-up
// pass after reset.
module led_matrix_row_scanner_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [5:0] row_number, [69:6] row_bits, [70] mirror, [71] zero
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] panel_half, [1] left_bit, [2] right_bit, [10:3] row_select, [15:11] zero
  output logic [15:0] out_tdata,
  // [1:0] step_kind
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);

  lmrs_pkg::lmrs_entry_t front_entry;
  lmrs_pkg::lmrs_entry_t q_entry;
  logic [lmrs_pkg::ENTRY_W-1:0] q_data;
  logic                  q_full;
  logic                  q_not_empty;
  logic                  q_pop;
  logic                  push;
  lmrs_pkg::step_kind_t  step_kind;
  logic                  panel_half;
  logic                  left_bit;
  logic                  right_bit;
  logic [7:0]            row_select;

  // Input side: accept while the queue has room.
  assign in_tready = ~q_full;
  assign push      = in_tvalid & ~q_full;

  lmrs_front u_front (
    .row_number (in_tdata[5:0]),
    .row_bits   (in_tdata[69:6]),
    .mirror     (in_tdata[70]),
    .entry      (front_entry)
  );

  lmrs_queue #(
    .WIDTH (lmrs_pkg::ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_data)
  );

  assign q_entry = q_data;

  lmrs_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_entry     (q_entry),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_kind    (step_kind),
    .out_half    (panel_half),
    .out_left    (left_bit),
    .out_right   (right_bit),
    .out_sel     (row_select),
    .out_last    (out_tlast)
  );

  // Result packing.
  assign out_tdata = {5'b0, row_select, right_bit, left_bit, panel_half};
  assign out_tuser = step_kind;

endmodule
